FILE: hw/rtl/rgbf_pkg.sv
// ---------------------------------------------------------------------------
// rgbf_pkg
// Types and constants shared by the colour fade and brightness core.
// ---------------------------------------------------------------------------
package rgbf_pkg;

   localparam int unsigned NUM_CHANNELS = 3;
   localparam int unsigned QUOT_BITS    = 8;

   // command codes
   localparam logic [2:0] CMD_TICK     = 3'd0;
   localparam logic [2:0] CMD_SET      = 3'd1;
   localparam logic [2:0] CMD_FADE     = 3'd2;
   localparam logic [2:0] CMD_BRIGHTER = 3'd3;
   localparam logic [2:0] CMD_DARKER   = 3'd4;

   localparam logic [7:0] LEVEL_RESET      = 8'd127;
   localparam logic [7:0] LEVEL_STEP       = 8'd8;
   localparam logic [7:0] LEVEL_FROM_ZERO  = 8'd7;
   localparam logic [7:0] LEVEL_RISE_LIMIT = 8'd247;
   localparam logic [7:0] FULL_SCALE       = 8'd255;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       fading;
   } rsp_type;

   // request to the shared multiply/divide unit: floor(a * b / den)
   typedef struct packed {
      logic       start;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] den;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] quot;
      logic       rem_nz;
   } div_rsp_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_ITER
   } div_state_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_FADE_GO,
      SEQ_FADE_WAIT,
      SEQ_SCALE_GO,
      SEQ_SCALE_WAIT,
      SEQ_DONE
   } seq_state_type;

endpackage

FILE: hw/rtl/rgbf_muldiv.sv
// ---------------------------------------------------------------------------
// rgbf_muldiv
// Shared unit: 8x8 multiply, then restoring division, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rgbf_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbf_pkg::div_req_type div_req,
   output rgbf_pkg::div_rsp_type div_rsp
);

   localparam int unsigned CountWidth = $clog2(rgbf_pkg::QUOT_BITS);

   rgbf_pkg::div_state_type state_ff, state_in;
   logic [7:0]              a_ff, a_in;
   logic [7:0]              b_ff, b_in;
   logic [7:0]              den_ff, den_in;
   logic [15:0]             work_ff, work_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    done_ff, done_in;

   logic [8:0] trial;
   logic [8:0] trial_diff;
   logic       trial_ge;

   // work holds {partial remainder, dividend bits still to go / quotient bits}
   assign trial      = work_ff[15:7];
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      den_in   = den_ff;
      work_in  = work_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      case (state_ff)
         rgbf_pkg::DIV_IDLE: begin
            if (div_req.start) begin
               a_in     = div_req.a;
               b_in     = div_req.b;
               den_in   = div_req.den;
               state_in = rgbf_pkg::DIV_MUL;
            end
         end
         rgbf_pkg::DIV_MUL: begin
            // quotient fits 8 bits: product high byte is always below den
            work_in  = {8'd0, a_ff} * {8'd0, b_ff};
            count_in = '0;
            state_in = rgbf_pkg::DIV_ITER;
         end
         rgbf_pkg::DIV_ITER: begin
            work_in  = {(trial_ge ? trial_diff[7:0] : trial[7:0]), work_ff[6:0], trial_ge};
            count_in = count_ff + 1'b1;
            if (count_ff == CountWidth'(rgbf_pkg::QUOT_BITS - 1)) begin
               done_in  = 1'b1;
               state_in = rgbf_pkg::DIV_IDLE;
            end
         end
         default: state_in = rgbf_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgbf_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      den_ff   <= den_in;
      work_ff  <= work_in;
      count_ff <= count_in;
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.quot   = work_ff[7:0];
   assign div_rsp.rem_nz = |work_ff[15:8];

endmodule

FILE: hw/rtl/rgb_fade_with_brightness_core.sv
// ---------------------------------------------------------------------------
// rgb_fade_with_brightness_core
// LED colour driver: set, linear fade, brightness, one scaled colour per item.
// ---------------------------------------------------------------------------
//  channel | ports                          | payload
//  input   | req_valid, req_stall, req_data | rgbf_pkg::req_type
//  result  | rsp_valid, rsp_stall, rsp_data | rgbf_pkg::rsp_type
//
//  Every item uses the shared multiply/divide unit three times for brightness
//  scaling; a tick that advances a fade uses it three more times for the step.
//  Reset has no clearing pass.
//  A result held by rsp_stall does not block the next input transfer; a
//  second finished result waits in the core until the first has gone.
// ---------------------------------------------------------------------------
module rgb_fade_with_brightness_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rgbf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rgbf_pkg::rsp_type rsp_data
);

   localparam logic [1:0] LastCh = 2'(rgbf_pkg::NUM_CHANNELS - 1);

   rgbf_pkg::seq_state_type state_ff, state_in;
   rgbf_pkg::req_type       req_ff, req_in;
   logic [1:0]              ch_ff, ch_in;
   logic [7:0]              current_ff [rgbf_pkg::NUM_CHANNELS];
   logic [7:0]              current_in [rgbf_pkg::NUM_CHANNELS];
   logic [7:0]              start_ff   [rgbf_pkg::NUM_CHANNELS];
   logic [7:0]              start_in   [rgbf_pkg::NUM_CHANNELS];
   logic signed [8:0]       delta_ff   [rgbf_pkg::NUM_CHANNELS];
   logic signed [8:0]       delta_in   [rgbf_pkg::NUM_CHANNELS];
   logic [7:0]              scaled_ff  [rgbf_pkg::NUM_CHANNELS];
   logic [7:0]              scaled_in  [rgbf_pkg::NUM_CHANNELS];
   logic [7:0]              length_ff, length_in;
   logic [7:0]              step_ff, step_in;
   logic [7:0]              level_ff, level_in;
   logic                    active_ff, active_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rgbf_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   rgbf_pkg::div_req_type div_req;
   rgbf_pkg::div_rsp_type div_rsp;

   logic [7:0]        tgt      [rgbf_pkg::NUM_CHANNELS];
   logic signed [8:0] diff     [rgbf_pkg::NUM_CHANNELS];
   logic [7:0]        diff_mag [rgbf_pkg::NUM_CHANNELS];
   logic [7:0]        len_01;
   logic [7:0]        fade_len;
   logic [8:0]        neg_delta;
   logic [7:0]        delta_mag;
   logic              delta_neg;
   logic [8:0]        q_down;
   logic [9:0]        fade_sum;
   logic [7:0]        fade_val;

   assign tgt[0] = req_ff.red;
   assign tgt[1] = req_ff.green;
   assign tgt[2] = req_ff.blue;

   always_comb begin
      for (int c = 0; c < rgbf_pkg::NUM_CHANNELS; c++) begin
         diff[c]     = $signed({1'b0, tgt[c]}) - $signed({1'b0, current_ff[c]});
         diff_mag[c] = diff[c][8] ? 8'(-diff[c]) : diff[c][7:0];
      end
   end

   assign len_01   = (diff_mag[1] > diff_mag[0]) ? diff_mag[1] : diff_mag[0];
   assign fade_len = (diff_mag[2] > len_01) ? diff_mag[2] : len_01;

   // fade channel: start + floor(delta * step / length), floor towards minus infinity
   assign delta_neg = delta_ff[ch_ff][8];
   assign neg_delta = 9'(-delta_ff[ch_ff]);
   assign delta_mag = delta_neg ? neg_delta[7:0] : delta_ff[ch_ff][7:0];
   assign q_down    = {1'b0, div_rsp.quot} + {8'd0, div_rsp.rem_nz};
   assign fade_sum  = delta_neg ? ({2'b00, start_ff[ch_ff]} - {1'b0, q_down})
                                : ({2'b00, start_ff[ch_ff]} + {2'b00, div_rsp.quot});

   always_comb begin
      if (fade_sum[9]) begin
         fade_val = 8'd0;
      end else if (fade_sum[8]) begin
         fade_val = 8'hFF;
      end else begin
         fade_val = fade_sum[7:0];
      end
   end

   always_comb begin
      div_req.start = (state_ff == rgbf_pkg::SEQ_FADE_GO) ||
                      (state_ff == rgbf_pkg::SEQ_SCALE_GO);
      if (state_ff == rgbf_pkg::SEQ_FADE_GO) begin
         div_req.a   = delta_mag;
         div_req.b   = step_ff;
         div_req.den = length_ff;
      end else begin
         div_req.a   = current_ff[ch_ff];
         div_req.b   = level_ff;
         div_req.den = rgbf_pkg::FULL_SCALE;
      end
   end

   rgbf_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ch_in        = ch_ff;
      current_in   = current_ff;
      start_in     = start_ff;
      delta_in     = delta_ff;
      scaled_in    = scaled_ff;
      length_in    = length_ff;
      step_in      = step_ff;
      level_in     = level_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rgbf_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = rgbf_pkg::SEQ_EXEC;
            end
         end
         rgbf_pkg::SEQ_EXEC: begin
            ch_in    = 2'd0;
            state_in = rgbf_pkg::SEQ_SCALE_GO;
            case (req_ff.cmd)
               rgbf_pkg::CMD_TICK: begin
                  if (active_ff) begin
                     step_in  = step_ff + 1'b1;
                     state_in = rgbf_pkg::SEQ_FADE_GO;
                  end
               end
               rgbf_pkg::CMD_SET: begin
                  active_in  = 1'b0;
                  current_in = tgt;
               end
               rgbf_pkg::CMD_FADE: begin
                  start_in  = current_ff;
                  delta_in  = diff;
                  length_in = fade_len;
                  step_in   = 8'd0;
                  active_in = fade_len != 8'd0;
               end
               rgbf_pkg::CMD_BRIGHTER: begin
                  active_in = 1'b0;
                  if (level_ff == 8'd0) begin
                     level_in = rgbf_pkg::LEVEL_FROM_ZERO;
                  end else if (level_ff <= rgbf_pkg::LEVEL_RISE_LIMIT) begin
                     level_in = level_ff + rgbf_pkg::LEVEL_STEP;
                  end
               end
               rgbf_pkg::CMD_DARKER: begin
                  active_in = 1'b0;
                  if (level_ff >= rgbf_pkg::LEVEL_STEP) begin
                     level_in = level_ff - rgbf_pkg::LEVEL_STEP;
                  end else begin
                     level_in = 8'd0;
                  end
               end
               default: ;
            endcase
         end
         rgbf_pkg::SEQ_FADE_GO: state_in = rgbf_pkg::SEQ_FADE_WAIT;
         rgbf_pkg::SEQ_FADE_WAIT: begin
            if (div_rsp.done) begin
               current_in[ch_ff] = fade_val;
               if (ch_ff == LastCh) begin
                  // the step that reaches the length lands on the target
                  active_in = step_ff != length_ff;
                  ch_in     = 2'd0;
                  state_in  = rgbf_pkg::SEQ_SCALE_GO;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = rgbf_pkg::SEQ_FADE_GO;
               end
            end
         end
         rgbf_pkg::SEQ_SCALE_GO: state_in = rgbf_pkg::SEQ_SCALE_WAIT;
         rgbf_pkg::SEQ_SCALE_WAIT: begin
            if (div_rsp.done) begin
               scaled_in[ch_ff] = div_rsp.quot;
               if (ch_ff == LastCh) begin
                  ch_in    = 2'd0;
                  state_in = rgbf_pkg::SEQ_DONE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = rgbf_pkg::SEQ_SCALE_GO;
               end
            end
         end
         rgbf_pkg::SEQ_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_red   = scaled_ff[0];
               rsp_data_in.out_green = scaled_ff[1];
               rsp_data_in.out_blue  = scaled_ff[2];
               rsp_data_in.fading    = active_ff;
               state_in              = rgbf_pkg::SEQ_IDLE;
            end
         end
         default: state_in = rgbf_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rgbf_pkg::SEQ_IDLE;
         ch_ff        <= 2'd0;
         current_ff   <= '{default: 8'd0};
         start_ff     <= '{default: 8'd0};
         delta_ff     <= '{default: 9'sd0};
         length_ff    <= 8'd0;
         step_ff      <= 8'd0;
         level_ff     <= rgbf_pkg::LEVEL_RESET;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         current_ff   <= current_in;
         start_ff     <= start_in;
         delta_ff     <= delta_in;
         length_ff    <= length_in;
         step_ff      <= step_in;
         level_ff     <= level_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scaled_ff   <= scaled_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != rgbf_pkg::SEQ_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/rgbf_chk.sv
// ---------------------------------------------------------------------------
// rgbf_chk
// Port-level checks for the colour fade core, bound to the top level.
// ---------------------------------------------------------------------------
module rgbf_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rgbf_pkg::rsp_type rsp_data
);

   // a held result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result changed");

   // one item at a time: stall rises straight after an input transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second input transfer while busy");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind rgb_fade_with_brightness_core rgbf_chk u_rgbf_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
